### hdl/mbd_pkg.sv
package mbd_pkg;

    // number of buttons served; the fields below carry at most eight of them
    localparam int BUTTON_COUNT = 8;
    localparam int FIELD_W      = 8;
    localparam int LANES        = (BUTTON_COUNT < FIELD_W) ? BUTTON_COUNT : FIELD_W;

    localparam int CNT_W   = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] MAX_COUNT_RST   = 8'd16;
    localparam logic [CFG_W-1:0] ACTIVE_HIGH_RST = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_COUNT   = 1'b0,
        CFG_ACTIVE_HIGH = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_UNKNOWN = 2'd0,
        ST_OFF     = 2'd1,
        ST_ON      = 2'd2
    } status_t;

    // what one lane reports for the current tick
    typedef struct packed {
        logic press;
        logic release_ev;
        logic held;
        logic known;
    } lane_res_t;

    typedef struct packed {
        logic [FIELD_W-1:0] press_events;
        logic [FIELD_W-1:0] release_events;
        logic [FIELD_W-1:0] held_state;
        logic [FIELD_W-1:0] state_known;
    } mbd_res_t;

endpackage

### hdl/mbd_if.sv
interface mbd_in_if;
    logic                        valid;
    logic                        ready;
    logic [mbd_pkg::FIELD_W-1:0] pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

interface mbd_out_if;
    logic                        valid;
    logic                        ready;
    logic [mbd_pkg::FIELD_W-1:0] press_events;
    logic [mbd_pkg::FIELD_W-1:0] release_events;
    logic [mbd_pkg::FIELD_W-1:0] held_state;
    logic [mbd_pkg::FIELD_W-1:0] state_known;

    modport source (output valid, output press_events, output release_events,
                    output held_state, output state_known, input ready);
    modport sink   (input valid, input press_events, input release_events,
                    input held_state, input state_known, output ready);
endinterface

### hdl/multi_button_debouncer_unit.sv
// Multi-button integrating debouncer.
//
// in_ch  : one transfer per tick, pin_levels carries the sampled level of
//          every button (bit i is button i).
// out_ch : one transfer per input transfer, with press/release event masks
//          and the held/known state masks as they stand after that tick.
// cfg    : cfg_we/cfg_index/cfg_wdata, index 0 max_count, index 1
//          active_high_mask. Writing max_count restarts every integrator at
//          half the new ceiling with the state unknown. Write only when idle.
//
// Results sit in the output register the cycle after the input transfer.
// Throughput is one tick per cycle while the receiver keeps up; each button
// has its own lane (counter plus state), with no counter or state shared.
// in_ch.ready is high whenever the output register is empty or is being
// drained in the same cycle, so a stalled receiver holds back the next tick
// only once the single output stage is full.
// Reset: max_count 16, all polarities active low, integrators at 8, states
// unknown, output register empty.
module multi_button_debouncer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    mbd_in_if.sink                        in_ch,
    mbd_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbd_pkg::CFG_W-1:0]     cfg_wdata
);

    logic [mbd_pkg::CNT_W-1:0]   max_count_reg;
    logic [mbd_pkg::FIELD_W-1:0] active_high_reg;
    logic [mbd_pkg::CNT_W-1:0]   lane_max;
    logic                        restart;
    logic                        step;
    logic                        out_valid;
    mbd_pkg::mbd_res_t           out_res;
    mbd_pkg::lane_res_t [mbd_pkg::LANES-1:0] lane_res;

    // config registers; a ceiling write also restarts the lanes
    assign restart = cfg_we && (cfg_index == mbd_pkg::CFG_MAX_COUNT);

    // lanes restart from the ceiling being written, not the old one
    assign lane_max = restart ? cfg_wdata : max_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg   <= mbd_pkg::MAX_COUNT_RST;
            active_high_reg <= mbd_pkg::ACTIVE_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbd_pkg::CFG_MAX_COUNT:   max_count_reg   <= cfg_wdata;
                mbd_pkg::CFG_ACTIVE_HIGH: active_high_reg <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // accept a tick whenever the output stage is free or empties now
    assign in_ch.ready = !out_valid || out_ch.ready;
    assign step        = in_ch.valid && in_ch.ready;

    // one lane per button; pressed when the level matches the polarity bit
    for (genvar g = 0; g < mbd_pkg::LANES; g++)
    begin : g_lane
        mbd_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .restart   (restart),
            .max_count (lane_max),
            .step      (step),
            .pressed   (in_ch.pin_levels[g] == active_high_reg[g]),
            .res       (lane_res[g])
        );
    end

    // merge lane flags into masks and hold them for the receiver
    mbd_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .drain    (out_ch.ready),
        .lane_res (lane_res),
        .valid    (out_valid),
        .res      (out_res)
    );

    assign out_ch.valid          = out_valid;
    assign out_ch.press_events   = out_res.press_events;
    assign out_ch.release_events = out_res.release_events;
    assign out_ch.held_state     = out_res.held_state;
    assign out_ch.state_known    = out_res.state_known;

    // a transfer in always leaves a result waiting next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_ch.valid)
        else $error("no result after input transfer");

    // an empty output stage never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output stage");

    // a button cannot be pressed and released in one tick
    a_events_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((out_ch.press_events & out_ch.release_events) == '0))
        else $error("press and release on the same button");

    // a press leaves the button held, and held implies known
    a_state_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (((out_ch.press_events & ~out_ch.held_state) == '0)
                       && ((out_ch.held_state & ~out_ch.state_known) == '0)))
        else $error("event and state masks disagree");

endmodule

### hdl/mbd_lane.sv
module mbd_lane (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      restart,
    input  logic [mbd_pkg::CNT_W-1:0] max_count,
    input  logic                      step,
    input  logic                      pressed,
    output mbd_pkg::lane_res_t        res
);

    logic [mbd_pkg::CNT_W-1:0] integ_reg;
    logic [mbd_pkg::CNT_W-1:0] integ_next;
    mbd_pkg::status_t          status_reg;
    mbd_pkg::status_t          status_next;
    logic                      press;
    logic                      release_ev;

    always_comb
    begin
        integ_next  = integ_reg;
        status_next = status_reg;
        press       = 1'b0;
        release_ev  = 1'b0;
        if (pressed)
        begin
            if (integ_reg != '0)
            begin
                integ_next = integ_reg - 1'b1;
                if (integ_next == '0)
                begin
                    press       = (status_reg == mbd_pkg::ST_OFF);
                    status_next = mbd_pkg::ST_ON;
                end
            end
        end
        else
        begin
            if (integ_reg < max_count)
            begin
                integ_next = integ_reg + 1'b1;
                if (integ_next == max_count)
                begin
                    release_ev  = (status_reg == mbd_pkg::ST_ON);
                    status_next = mbd_pkg::ST_OFF;
                end
            end
        end
    end

    always_comb
    begin
        res.press      = press;
        res.release_ev = release_ev;
        res.held       = (status_next == mbd_pkg::ST_ON);
        res.known      = (status_next != mbd_pkg::ST_UNKNOWN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg  <= mbd_pkg::MAX_COUNT_RST >> 1;
            status_reg <= mbd_pkg::ST_UNKNOWN;
        end
        else if (restart)
        begin
            integ_reg  <= max_count >> 1;
            status_reg <= mbd_pkg::ST_UNKNOWN;
        end
        else if (step)
        begin
            integ_reg  <= integ_next;
            status_reg <= status_next;
        end
    end

endmodule

### hdl/mbd_merge.sv
module mbd_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load,
    input  logic                                   drain,
    input  mbd_pkg::lane_res_t [mbd_pkg::LANES-1:0] lane_res,
    output logic                                   valid,
    output mbd_pkg::mbd_res_t                      res
);

    mbd_pkg::mbd_res_t res_reg;
    mbd_pkg::mbd_res_t res_next;
    logic              valid_reg;
    logic              valid_next;

    // gather lane flags into masks; bits with no lane stay clear
    always_comb
    begin
        res_next = '0;
        for (int i = 0; i < mbd_pkg::LANES; i++)
        begin
            res_next.press_events[i]   = lane_res[i].press;
            res_next.release_events[i] = lane_res[i].release_ev;
            res_next.held_state[i]     = lane_res[i].held;
            res_next.state_known[i]    = lane_res[i].known;
        end
    end

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (drain)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign valid = valid_reg;
    assign res   = res_reg;

endmodule
